FILE: rtl/b64sc_pkg.sv
// shared types, character constants and alphabet functions of the base64 codec
// no dependencies
package b64sc_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_CHAR_62   = 2'd1;
  localparam logic [1:0] REG_CHAR_63   = 2'd2;
  localparam logic [1:0] REG_PAD_CHAR  = 2'd3;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_EQUALS  = 8'h3d;

  typedef struct packed {
    logic       dir;
    logic [7:0] c62;
    logic [7:0] c63;
    logic [7:0] pad;
  } cfg_t;

  // results of one input item
  typedef struct packed {
    logic [2:0]         n;
    logic [3:0][7:0]    data;
    logic [3:0]         last;
    logic               bad;
  } res_t;

  function automatic logic [7:0] enc_char(logic [5:0] v, logic [7:0] c62, logic [7:0] c63);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(CH_UPPER_A + {2'b00, v});
    end else if (v < 6'd52) begin
      r = 8'(CH_LOWER_A + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      r = 8'(CH_DIGIT_0 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      r = c62;
    end else begin
      r = c63;
    end
    return r;
  endfunction

  // bit 6 set marks an invalid character
  function automatic logic [6:0] dec_value(logic [7:0] ch, logic [7:0] c62, logic [7:0] c63);
    logic [6:0] r;
    if (ch == c63) begin
      r = 7'd63;
    end else if (ch == c62) begin
      r = 7'd62;
    end else if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      r = 7'(ch - CH_UPPER_A);
    end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      r = 7'(ch - CH_LOWER_A + 8'd26);
    end else if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
      r = 7'(ch - CH_DIGIT_0 + 8'd52);
    end else if (ch == CH_PLUS) begin
      r = 7'd62;
    end else if (ch == CH_SLASH) begin
      r = 7'd63;
    end else begin
      r = 7'd64;
    end
    return r;
  endfunction

endpackage

FILE: rtl/base64_stream_codec.sv
// top level of the message-framed base64 codec: configuration registers,
// input register, group logic and result buffer; depends on b64sc_pkg,
// b64sc_step and b64sc_obuf
//
//  channel  | direction | payload
//  s_axis   | in        | tdata = in_byte[7:0], tlast = in_last
//  m_axis   | out       | tdata = out_byte[7:0], tlast = out_last, tuser = bad_input
//  cfg      | in        | cfg_index selects register, cfg_data[7:0] written when cfg_we
//
// an item leaves the input register once the result buffer is empty or on its
// last transfer, and a new input transfer is taken in that same cycle; results
// pass through the input register and the result buffer and leave at one output
// transfer per cycle while m_tready stays high; an encode group of three bytes gives
// four output transfers and a decode group of four characters up to three
// rst (synchronous) restores the default alphabet, encode mode and empty state
// a stalled output keeps the item in the input register until the buffer frees
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte[7:0]
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast,
  output logic       m_tuser,   // bad_input
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  b64sc_pkg::cfg_t cfg;
  b64sc_pkg::res_t res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       can_load;
  logic       advance;
  logic       dir_write;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir <= b64sc_pkg::DIR_ENCODE;
      cfg.c62 <= b64sc_pkg::CH_PLUS;
      cfg.c63 <= b64sc_pkg::CH_SLASH;
      cfg.pad <= b64sc_pkg::CH_EQUALS;
    end else if (cfg_we) begin
      case (cfg_index)
        b64sc_pkg::REG_DIRECTION: cfg.dir <= cfg_data[0];
        b64sc_pkg::REG_CHAR_62:   cfg.c62 <= cfg_data;
        b64sc_pkg::REG_CHAR_63:   cfg.c63 <= cfg_data;
        b64sc_pkg::REG_PAD_CHAR:  cfg.pad <= cfg_data;
        default: ;
      endcase
    end
  end

  // a direction write drops any partial message
  assign dir_write = cfg_we && (cfg_index == b64sc_pkg::REG_DIRECTION);

  // input register: item moves on once the result buffer can take its results
  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  b64sc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .clear   (dir_write),
    .load    (advance),
    .in_byte (in_byte),
    .in_last (in_last),
    .cfg     (cfg),
    .res     (res)
  );

  b64sc_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // a held item that cannot move on keeps its contents
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !can_load) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("input register lost a waiting item");

endmodule

FILE: rtl/b64sc_step.sv
// group state and per-item encode / decode logic of the base64 codec
// depends on b64sc_pkg
module b64sc_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              load,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  b64sc_pkg::cfg_t   cfg,
  output b64sc_pkg::res_t   res
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [1:0]  pad_seen, pad_seen_next;
  logic        error_sticky, error_sticky_next;

  logic [1:0]  epos, held;
  logic [23:0] ebits, eshift;
  logic [6:0]  dv;
  logic        bad_ch, is_pad, bad4, err;
  logic [1:0]  pads;
  logic [23:0] dbits, dshift;
  logic [1:0]  nb;

  always_comb begin
    res              = '0;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_seen_next    = pad_seen;
    error_sticky_next = error_sticky;

    // encode side
    epos = (group_count > 2'd2) ? 2'd2 : group_count;
    case (epos)
      2'd0:    eshift = {in_byte, 16'h0};
      2'd1:    eshift = {8'h0, in_byte, 8'h0};
      default: eshift = {16'h0, in_byte};
    endcase
    ebits = group_bits | eshift;
    held  = 2'(epos + 2'd1);

    // decode side
    dv     = b64sc_pkg::dec_value(in_byte, cfg.c62, cfg.c63);
    bad_ch = dv[6];
    is_pad = (in_byte == cfg.pad);
    case (group_count)
      2'd0:    dshift = {dv[5:0], 18'h0};
      2'd1:    dshift = {6'h0, dv[5:0], 12'h0};
      default: dshift = {12'h0, dv[5:0], 6'h0};
    endcase
    bad4  = bad_ch;
    pads  = (in_last && is_pad) ? (pad_seen[0] ? 2'd2 : 2'd1) : 2'd0;
    err   = error_sticky || (bad4 && pads == 2'd0) || (pad_seen[1] && pads != 2'd2);
    dbits = group_bits | ((!bad4 && pads == 2'd0) ? {18'h0, dv[5:0]} : 24'h0);
    nb    = 2'(2'd3 - pads);

    if (cfg.dir == b64sc_pkg::DIR_ENCODE) begin
      if (held != 2'd3 && !in_last) begin
        group_bits_next  = ebits;
        group_count_next = held;
      end else begin
        res.n       = 3'd4;
        res.data[0] = b64sc_pkg::enc_char(ebits[23:18], cfg.c62, cfg.c63);
        res.data[1] = b64sc_pkg::enc_char(ebits[17:12], cfg.c62, cfg.c63);
        res.data[2] = (held >= 2'd2) ? b64sc_pkg::enc_char(ebits[11:6], cfg.c62, cfg.c63)
                                     : cfg.pad;
        res.data[3] = (held == 2'd3) ? b64sc_pkg::enc_char(ebits[5:0], cfg.c62, cfg.c63)
                                     : cfg.pad;
        res.last[3] = in_last;
        group_bits_next   = '0;
        group_count_next  = '0;
        pad_seen_next     = '0;
        error_sticky_next = 1'b0;
      end
    end else if (in_last && group_count != 2'd3) begin
      // length not a multiple of four
      res.n       = 3'd1;
      res.last[0] = 1'b1;
      res.bad     = 1'b1;
      group_bits_next   = '0;
      group_count_next  = '0;
      pad_seen_next     = '0;
      error_sticky_next = 1'b0;
    end else if (group_count != 2'd3) begin
      if (group_count == 2'd2) begin
        pad_seen_next = {bad_ch, is_pad};
      end else if (bad_ch) begin
        error_sticky_next = 1'b1;
      end
      if (!bad_ch) begin
        group_bits_next = group_bits | dshift;
      end
      group_count_next = 2'(group_count + 2'd1);
    end else begin
      group_bits_next  = '0;
      group_count_next = '0;
      pad_seen_next    = '0;
      if (err) begin
        if (in_last) begin
          res.n       = 3'd1;
          res.last[0] = 1'b1;
          res.bad     = 1'b1;
          error_sticky_next = 1'b0;
        end else begin
          error_sticky_next = 1'b1;
        end
      end else begin
        res.n       = {1'b0, nb};
        res.data[0] = dbits[23:16];
        res.data[1] = dbits[15:8];
        res.data[2] = dbits[7:0];
        res.last[nb - 2'd1] = in_last;
        error_sticky_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      group_bits   <= '0;
      group_count  <= '0;
      pad_seen     <= '0;
      error_sticky <= 1'b0;
    end else if (load) begin
      group_bits   <= group_bits_next;
      group_count  <= group_count_next;
      pad_seen     <= pad_seen_next;
      error_sticky <= error_sticky_next;
    end
  end

  // encode groups close at three bytes, so a full count only arises in decode
  a_enc_count: assert property (@(posedge clk) disable iff (rst)
    (cfg.dir == b64sc_pkg::DIR_ENCODE) |-> (group_count != 2'd3))
    else $error("encode group count reached three");

endmodule

FILE: rtl/b64sc_obuf.sv
// result buffer of the base64 codec: holds the results of one item and gives one
// transfer a cycle while m_tready is high; depends on b64sc_pkg
module b64sc_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64sc_pkg::res_t   res,
  output logic              can_load,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  logic [2:0]      cnt;
  logic [1:0]      idx;
  logic [3:0][7:0] data;
  logic [3:0]      last;
  logic            bad;
  logic            take;

  assign m_tvalid = (cnt != 3'd0);
  assign take     = m_tvalid && m_tready;
  assign can_load = (cnt == 3'd0) || (cnt == 3'd1 && m_tready);
  assign m_tdata  = data[idx];
  assign m_tlast  = last[idx];
  assign m_tuser  = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load && res.n != 3'd0) begin
      cnt <= res.n;
      idx <= '0;
    end else if (take) begin
      cnt <= 3'(cnt - 3'd1);
      idx <= 2'(idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.n != 3'd0) begin
      data <= res.data;
      last <= res.last;
      bad  <= res.bad;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result count above four");

  a_bad_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00 && cnt == 3'd1))
    else $error("error result not a single zero final transfer");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (load && res.n != 3'd0) |-> can_load)
    else $error("results loaded over pending ones");

endmodule
